### src/bmv_pkg.sv
// Shared widths and defaults for the majority vote block.
package bmv_pkg;

  localparam int DATA_W        = 32;
  localparam int OCC_W         = 11;
  localparam int MAX_ITEMS_DEF = 1024;

  typedef logic signed [DATA_W-1:0] data_t;
  typedef logic [OCC_W-1:0]         occ_t;

endpackage

### src/bmv_front.sv
// Front end: accepts requests, runs the vote, writes the store, queues one job per run.
module bmv_front import bmv_pkg::*; #(
  parameter int MAX_ITEMS = MAX_ITEMS_DEF,
  localparam int CW = $clog2(MAX_ITEMS + 2),
  localparam int AW = $clog2(MAX_ITEMS)
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  output logic          busy,
  input  data_t         in_value,
  input  logic          in_last_item,
  output logic          wr_en,
  output logic [AW-1:0] wr_addr,
  output data_t         wr_data,
  output logic          job_vld,
  output data_t         job_cand,
  output logic [CW-1:0] job_len,
  output logic          job_ovf,
  input  logic          job_pop
);

  localparam int VW = $clog2(2 * MAX_ITEMS);
  localparam logic [CW-1:0] MAX_C      = CW'(MAX_ITEMS);
  localparam logic [CW-1:0] MAX_P1     = CW'(MAX_ITEMS + 1);
  localparam logic [VW-1:0] VOTE_LIMIT = VW'(2 * MAX_ITEMS - 1);

  data_t         cand_r, cand_nxt;
  logic [VW-1:0] vc_r, vc_nxt;
  logic [CW-1:0] rl_r, rl_nxt;
  logic          ovf_r, ovf_nxt;
  logic          job_vld_r, guard_r;
  data_t         job_cand_r;
  logic [CW-1:0] job_len_r;
  logic          job_ovf_r;
  logic          accept;

  assign busy   = job_vld_r | guard_r;
  assign accept = start & ~busy;

  always_comb begin
    cand_nxt = cand_r;
    vc_nxt   = vc_r;
    priority if (in_value == cand_r) begin
      if (vc_r < VOTE_LIMIT) vc_nxt = vc_r + VW'(1);
    end else if (vc_r != '0) begin
      vc_nxt = vc_r - VW'(1);
    end else begin
      cand_nxt = in_value;
      vc_nxt   = VW'(1);
    end
    if (rl_r < MAX_C) begin
      rl_nxt  = rl_r + CW'(1);
      ovf_nxt = ovf_r;
    end else begin
      rl_nxt  = MAX_P1;
      ovf_nxt = 1'b1;
    end
  end

  assign wr_en   = accept & (rl_r < MAX_C);
  assign wr_addr = rl_r[AW-1:0];
  assign wr_data = in_value;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cand_r    <= '0;
      vc_r      <= '0;
      rl_r      <= '0;
      ovf_r     <= 1'b0;
      job_vld_r <= 1'b0;
      guard_r   <= 1'b0;
    end else begin
      // hold off a new run in the cycle after the job is popped so the rescan keeps ahead of writes
      guard_r <= job_pop;
      if (job_pop) job_vld_r <= 1'b0;
      if (accept) begin
        if (in_last_item) begin
          job_vld_r <= 1'b1;
          cand_r    <= '0;
          vc_r      <= '0;
          rl_r      <= '0;
          ovf_r     <= 1'b0;
        end else begin
          cand_r <= cand_nxt;
          vc_r   <= vc_nxt;
          rl_r   <= rl_nxt;
          ovf_r  <= ovf_nxt;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && in_last_item) begin
      job_cand_r <= cand_nxt;
      job_len_r  <= rl_nxt;
      job_ovf_r  <= ovf_nxt;
    end
  end

  assign job_vld  = job_vld_r;
  assign job_cand = job_cand_r;
  assign job_len  = job_len_r;
  assign job_ovf  = job_ovf_r;

endmodule

### src/bmv_back.sv
// Back end: item store, rescan counter and result register.
module bmv_back import bmv_pkg::*; #(
  parameter int MAX_ITEMS = MAX_ITEMS_DEF,
  localparam int CW = $clog2(MAX_ITEMS + 2),
  localparam int AW = $clog2(MAX_ITEMS)
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  data_t         wr_data,
  input  logic          job_vld,
  input  data_t         job_cand,
  input  logic [CW-1:0] job_len,
  input  logic          job_ovf,
  output logic          job_pop,
  output logic          out_valid,
  output data_t         out_majority_value,
  output occ_t          out_occurrences,
  output logic          out_is_majority,
  output logic          out_overflowed
);

  localparam logic [CW-1:0] MAX_C = CW'(MAX_ITEMS);

  typedef enum logic {ST_IDLE, ST_SCAN} state_t;

  data_t         mem [MAX_ITEMS];
  data_t         rd_data_r;
  state_t        state_r;
  logic [CW-1:0] idx_r, n_r, len_r, cnt_r;
  logic          rd_vld_r, ovf_r, out_valid_r;
  data_t         cand_r;
  data_t         res_val_r;
  occ_t          res_occ_r;
  logic          res_maj_r, res_ovf_r;
  logic          issue, done;

  assign job_pop = (state_r == ST_IDLE) & job_vld;
  assign issue   = (state_r == ST_SCAN) & (idx_r != n_r);
  assign done    = (state_r == ST_SCAN) & (idx_r == n_r) & ~rd_vld_r;

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    rd_data_r <= mem[idx_r[AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      rd_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
      idx_r       <= '0;
      cnt_r       <= '0;
    end else begin
      out_valid_r <= done;
      unique case (state_r)
        ST_IDLE: begin
          rd_vld_r <= 1'b0;
          if (job_vld) begin
            state_r <= ST_SCAN;
            idx_r   <= '0;
            cnt_r   <= '0;
          end
        end
        ST_SCAN: begin
          rd_vld_r <= issue;
          if (issue) idx_r <= idx_r + CW'(1);
          if (rd_vld_r && rd_data_r == cand_r) cnt_r <= cnt_r + CW'(1);
          if (done) state_r <= ST_IDLE;
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (job_pop) begin
      cand_r <= job_cand;
      len_r  <= job_len;
      ovf_r  <= job_ovf;
      n_r    <= job_ovf ? MAX_C : job_len;
    end
    if (done) begin
      res_val_r <= cand_r;
      res_occ_r <= OCC_W'(cnt_r);
      res_maj_r <= ~ovf_r & (cnt_r > (len_r >> 1));
      res_ovf_r <= ovf_r;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_majority_value = res_val_r;
  assign out_occurrences    = res_occ_r;
  assign out_is_majority    = res_maj_r;
  assign out_overflowed     = res_ovf_r;

endmodule

### src/majority_vote_with_check.sv
// Top level of the majority vote block with verifying rescan.
//
//   channel  | handshake          | payload
//   ---------+--------------------+--------------------------------------------
//   input    | start / busy       | in_value, in_last_item
//   result   | out_valid (strobe) | out_majority_value, out_occurrences,
//            |                    | out_is_majority, out_overflowed
//
// A run of n items loads at one item per cycle while busy is low.
// After the last item the rescan reads n' = min(n, MAX_ITEMS) stored items, one per
// cycle, through rd_data_r into cnt_r; the result registers and out_valid then load.
// After the last item busy is held high by job_vld_r until the back end takes the job,
// which waits while an earlier rescan is still running, and then by guard_r.
// Synchronous active-low reset clears all control state; the store is not cleared.
// The result is shown for one cycle and cannot be stalled.
module majority_vote_with_check import bmv_pkg::*; #(
  parameter int MAX_ITEMS = MAX_ITEMS_DEF
) (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  start,
  output logic  busy,
  input  data_t in_value,
  input  logic  in_last_item,
  output logic  out_valid,
  output data_t out_majority_value,
  output occ_t  out_occurrences,
  output logic  out_is_majority,
  output logic  out_overflowed
);

  localparam int CW = $clog2(MAX_ITEMS + 2);
  localparam int AW = $clog2(MAX_ITEMS);

  logic          wr_en;
  logic [AW-1:0] wr_addr;
  data_t         wr_data;
  logic          job_vld, job_ovf, job_pop;
  data_t         job_cand;
  logic [CW-1:0] job_len;

  bmv_front #(.MAX_ITEMS(MAX_ITEMS)) u_front (
    .clk, .rst_n, .start, .busy, .in_value, .in_last_item,
    .wr_en, .wr_addr, .wr_data,
    .job_vld, .job_cand, .job_len, .job_ovf, .job_pop
  );

  bmv_back #(.MAX_ITEMS(MAX_ITEMS)) u_back (
    .clk, .rst_n, .wr_en, .wr_addr, .wr_data,
    .job_vld, .job_cand, .job_len, .job_ovf, .job_pop,
    .out_valid, .out_majority_value, .out_occurrences,
    .out_is_majority, .out_overflowed
  );

endmodule

### src/bmv_checker.sv
// Port-level checks for the majority vote block, bound to the top level.
module bmv_checker import bmv_pkg::*; (
  input logic  clk,
  input logic  rst_n,
  input logic  start,
  input logic  busy,
  input logic  in_last_item,
  input logic  out_valid,
  input logic  out_is_majority,
  input logic  out_overflowed
);

  a_reset_idle: assert property (@(posedge clk) !rst_n |=> !busy && !out_valid)
    else $error("block not idle after reset");

  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe longer than one cycle");

  a_last_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && in_last_item |=> busy)
    else $error("request taken straight after end of run");

  a_ovf_no_major: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_overflowed |-> !out_is_majority)
    else $error("majority reported on overflowed run");

endmodule

bind majority_vote_with_check bmv_checker u_bmv_checker (
  .clk, .rst_n, .start, .busy, .in_last_item,
  .out_valid, .out_is_majority, .out_overflowed
);
